/* rtl/core/sop_pkg.sv */
// Shared types and constants of the second-operand shifter pipeline.
`default_nettype none

package sop_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned RotWidth = 5;

   localparam logic [1:0] KIND_LSL = 2'd0;
   localparam logic [1:0] KIND_LSR = 2'd1;
   localparam logic [1:0] KIND_ASR = 2'd2;
   localparam logic [1:0] KIND_ROR = 2'd3;

   localparam logic [3:0] OPC_LOGIC_LOW = 4'd0;
   localparam logic [3:0] OPC_LOGIC_HIGH_FIRST = 4'd8;

   localparam logic [WordWidth-1:0] WORD_ONES = '1;
   localparam logic [WordWidth-1:0] WORD_TOP_BIT = {1'b1, {(WordWidth-1){1'b0}}};

   typedef struct packed {
      logic [31:0] value;
      logic [7:0]  amount;
      logic [1:0]  shift_kind;
      logic        amount_is_immediate;
      logic [3:0]  alu_opcode;
      logic        set_flags;
      logic        carry_in;
   } req_type;

   typedef struct packed {
      logic [31:0] shifted;
      logic        carry_out;
      logic        carry_write;
   } rsp_type;

   typedef struct packed {
      logic [WordWidth-1:0] data;
      logic [RotWidth-1:0]  rot;
      logic [WordWidth-1:0] mask;
      logic                 fill;
      logic                 carry_out;
      logic                 carry_write;
   } stage_type;

endpackage

`default_nettype wire

/* rtl/core/sop_decode.sv */
// First stage: decodes the shift into a rotate amount, a fill mask and the final carry.
`default_nettype none

module sop_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire sop_pkg::req_type  in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output sop_pkg::stage_type     out_data,
   input  wire logic              out_ready
);

   logic               valid_ff, valid_in;
   sop_pkg::stage_type data_ff, data_in;
   logic               advance;

   always_comb begin
      logic [4:0]  amt_low;
      logic [4:0]  amt_dec;
      logic        amt_zero;
      logic        amt_big;
      logic        amt_is_32;
      logic        sign;
      logic        c;
      logic        write;

      amt_low   = in_data.amount[4:0];
      amt_dec   = amt_low - 5'd1;
      amt_zero  = (in_data.amount == 8'd0);
      amt_big   = (in_data.amount[7:5] != 3'd0);
      amt_is_32 = (in_data.amount == 8'd32);
      sign      = in_data.value[31];
      c         = in_data.carry_in;
      write     = in_data.set_flags &&
                  ((in_data.alu_opcode == sop_pkg::OPC_LOGIC_LOW) ||
                   (in_data.alu_opcode >= sop_pkg::OPC_LOGIC_HIGH_FIRST));

      data_in.data = in_data.value;
      data_in.rot  = '0;
      data_in.mask = '0;
      data_in.fill = 1'b0;

      unique case (in_data.shift_kind)
         sop_pkg::KIND_LSL: begin
            if (amt_zero) begin
               c = in_data.carry_in;
            end else if (amt_big) begin
               data_in.mask = sop_pkg::WORD_ONES;
               c = 1'b0;
            end else begin
               data_in.rot  = 5'd0 - amt_low;
               data_in.mask = ~(sop_pkg::WORD_ONES << amt_low);
               c = in_data.value[5'd0 - amt_low];
            end
         end
         sop_pkg::KIND_LSR: begin
            if (amt_zero) begin
               c = in_data.carry_in;
            end else if (!amt_big) begin
               data_in.rot  = amt_low;
               data_in.mask = ~(sop_pkg::WORD_ONES >> amt_low);
               c = in_data.value[amt_dec];
            end else begin
               data_in.mask = sop_pkg::WORD_ONES;
               c = amt_is_32 ? sign : 1'b0;
            end
         end
         sop_pkg::KIND_ASR: begin
            data_in.fill = sign;
            if (amt_zero || amt_big) begin
               data_in.mask = sop_pkg::WORD_ONES;
               c = sign;
            end else begin
               data_in.rot  = amt_low;
               data_in.mask = ~(sop_pkg::WORD_ONES >> amt_low);
               c = in_data.value[amt_dec];
            end
         end
         sop_pkg::KIND_ROR: begin
            if (amt_zero) begin
               if (in_data.amount_is_immediate) begin
                  data_in.rot  = 5'd1;
                  data_in.mask = sop_pkg::WORD_TOP_BIT;
                  data_in.fill = in_data.carry_in;
                  c = in_data.value[0];
                  write = 1'b1;
               end else begin
                  c = in_data.carry_in;
               end
            end else if (amt_low == 5'd0) begin
               c = sign;
            end else begin
               data_in.rot = amt_low;
               c = in_data.value[amt_dec];
            end
         end
         default: begin
            c = in_data.carry_in;
         end
      endcase

      data_in.carry_write = write;
      data_in.carry_out   = write ? c : in_data.carry_in;
   end

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/core/sop_rot_coarse.sv */
// Second stage: rotates the operand right by the whole-byte part of the rotate amount.
`default_nettype none

module sop_rot_coarse (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire sop_pkg::stage_type in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output sop_pkg::stage_type      out_data,
   input  wire logic               out_ready
);

   logic               valid_ff, valid_in;
   sop_pkg::stage_type data_ff, data_in;
   logic               advance;
   logic [63:0]        doubled;
   logic [63:0]        rotated;

   always_comb begin
      doubled = {in_data.data, in_data.data};
      rotated = doubled >> {in_data.rot[4:3], 3'b000};
      data_in = in_data;
      data_in.data = rotated[31:0];
      data_in.rot  = {2'b00, in_data.rot[2:0]};
   end

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/core/sop_rot_fine.sv */
// Third stage: finishes the rotation by up to seven bits and applies the fill mask.
`default_nettype none

module sop_rot_fine (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire sop_pkg::stage_type in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output sop_pkg::rsp_type        out_data,
   input  wire logic               out_ready
);

   logic             valid_ff, valid_in;
   sop_pkg::rsp_type data_ff, data_in;
   logic             advance;
   logic [63:0]      doubled;
   logic [63:0]      rotated;

   always_comb begin
      doubled = {in_data.data, in_data.data};
      rotated = doubled >> in_data.rot[2:0];
      data_in.shifted     = (rotated[31:0] & ~in_data.mask) |
                            (in_data.mask & {32{in_data.fill}});
      data_in.carry_out   = in_data.carry_out;
      data_in.carry_write = in_data.carry_write;
   end

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/core/shifter_operand_with_carry.sv */
// Top level of the second-operand barrel shifter with carry-out.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid, req_stall   sop_pkg::req_type
//   rsp      out        rsp_valid, rsp_stall   sop_pkg::rsp_type
//
// Each item passes three register stages: decode, byte rotate, bit rotate and mask.
// An item may enter in every cycle in which req_stall is low; its result passes the decode,
// byte-rotate and bit-rotate registers in turn and then shows on rsp_valid.
// Reset is synchronous and clears only the stage valid bits.
// A stall holds the output register; bubbles still close up, so req_stall rises only
// when every stage holds an item and the output is stalled.
`default_nettype none

module shifter_operand_with_carry (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sop_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sop_pkg::rsp_type      rsp_data
);

   logic               s1_ready, s2_ready, s3_ready;
   logic               s1_valid, s2_valid;
   sop_pkg::stage_type s1_data, s2_data;

   sop_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (s1_ready),
      .out_valid (s1_valid),
      .out_data  (s1_data),
      .out_ready (s2_ready)
   );

   sop_rot_coarse u_rot_coarse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .in_ready  (s2_ready),
      .out_valid (s2_valid),
      .out_data  (s2_data),
      .out_ready (s3_ready)
   );

   sop_rot_fine u_rot_fine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_data   (s2_data),
      .in_ready  (s3_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_ready (!rsp_stall)
   );

   assign req_stall = !s1_ready;

   a_free_output_frees_input : assert property (
      @(posedge clock) disable iff (reset) !rsp_stall |-> !req_stall
   ) else $error("input stalled although the output is free");

   a_full_pipe_stalls_input : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && s2_valid && s1_valid) |-> req_stall
   ) else $error("input accepted into a full stalled pipeline");

   a_latency_three : assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid
   ) else $error("item did not reach the output after three cycles");

   a_stage_order : assert property (
      @(posedge clock) disable iff (reset)
      (s2_valid && !s3_ready) |=> s2_valid
   ) else $error("held item lost from the middle stage");

endmodule

`default_nettype wire
